FILE: src/sequential_frame_allocator_unit_assert.svh
// ----------------------------------------------------------------------------
// Frame allocator assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SEQUENTIAL_FRAME_ALLOCATOR_UNIT_ASSERT_SVH
`define SEQUENTIAL_FRAME_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define SFA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SFA_ASSERT(label, prop, msg)

`define SFA_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: src/sfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame allocator package
// Widths, codes and shared types of the sequential frame allocator.
// ----------------------------------------------------------------------------
package sfa_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int FRAME_BYTES = 4096;
    localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);

    localparam int FRAME_W  = 52;
    localparam int ADDR_W   = 64;
    localparam int FUNC_W   = 2;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 2;
    localparam int MAP_W    = 5;

    localparam int RIDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W  = ($clog2(MAX_REGIONS + 1) > MAP_W) ? $clog2(MAX_REGIONS + 1) : MAP_W;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_MAP_ENTRIES = '0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_ALLOC = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_EXHAUSTED  = 2'd1,
        ST_NO_ENTRIES = 2'd2
    } status_t;

    typedef struct packed {
        logic [FRAME_W-1:0] first;
        logic [FRAME_W-1:0] last;
    } region_t;

    typedef struct packed {
        logic              we;
        logic [RIDX_W-1:0] waddr;
        region_t           wdata;
        logic [RIDX_W-1:0] raddr;
    } ram_req_t;

endpackage

FILE: src/sfa_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame allocator command channel
// Valid/ready channel carrying one load, start or allocate item.
// ----------------------------------------------------------------------------
interface sfa_cmd_if;
    import sfa_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic [INDEX_W-1:0]        entry_index;
    logic [FRAME_W-1:0]        region_start_frame;
    logic [FRAME_W-1:0]        region_end_frame;

    modport source (
        output valid, func, entry_index, region_start_frame, region_end_frame,
        input  ready
    );

    modport sink (
        input  valid, func, entry_index, region_start_frame, region_end_frame,
        output ready
    );
endinterface

FILE: src/sfa_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame allocator response channel
// Valid/ready channel carrying one frame address and status per item.
// ----------------------------------------------------------------------------
interface sfa_rsp_if;
    import sfa_pkg::*;

    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   frame_address;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, frame_address, status,
        input  ready
    );

    modport sink (
        input  valid, frame_address, status,
        output ready
    );
endinterface

FILE: src/sfa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/sfa_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame allocator register file
// APB-style port holding the map entry count.
// ----------------------------------------------------------------------------
module sfa_apb_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sfa_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sfa_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sfa_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [sfa_pkg::MAP_W-1:0]       map_entries
);
    import sfa_pkg::*;

    logic [MAP_W-1:0]     map_entries_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready && (reg_idx == REG_MAP_ENTRIES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_entries_reg <= '0;
        end
        else if (wr_en)
        begin
            map_entries_reg <= pwdata[MAP_W-1:0];
        end
    end

    assign prdata      = (reg_idx == REG_MAP_ENTRIES) ? APB_DATA_W'(map_entries_reg) : '0;
    assign map_entries = map_entries_reg;

endmodule

FILE: src/sfa_seq.sv
`timescale 1ns / 1ps
`include "sequential_frame_allocator_unit_assert.svh"
// ----------------------------------------------------------------------------
// Frame allocator sequencer
// Walks the region table through one shared frame comparator.
// ----------------------------------------------------------------------------
module sfa_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    sfa_cmd_if.sink                    cmd,
    sfa_rsp_if.source                  rsp,
    input  logic [sfa_pkg::MAP_W-1:0]  map_entries,
    output sfa_pkg::ram_req_t          ram_req,
    input  sfa_pkg::region_t           ram_rdata
);
    import sfa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_TEST_LO,
        S_TEST_HI,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [RIDX_W-1:0]  cur_region_reg, cur_region_next;
    logic [FRAME_W-1:0] last_frame_reg, last_frame_next;
    logic               none_given_reg, none_given_next;
    logic [CNT_W-1:0]   walk_reg, walk_next;
    logic [CNT_W-1:0]   usable_reg, usable_next;
    logic [ADDR_W-1:0]  res_addr_reg, res_addr_next;
    status_t            res_status_reg, res_status_next;
    logic               out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]  out_addr_reg, out_addr_next;
    status_t            out_status_reg, out_status_next;

    logic               cmd_fire;
    logic [CNT_W-1:0]   usable_raw;
    logic [CNT_W-1:0]   usable_c;
    logic [FRAME_W-1:0] cmp_b;
    logic               cmp_lt;
    logic [FRAME_W-1:0] frame_inc;

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;

    assign usable_raw = (map_entries == '0) ? '0 : CNT_W'(map_entries) - CNT_W'(1);
    assign usable_c   = (usable_raw > CNT_W'(MAX_REGIONS)) ? CNT_W'(MAX_REGIONS) : usable_raw;

    // shared frame comparator: region first frame, then region last frame
    assign cmp_b     = (state_reg == S_TEST_LO) ? ram_rdata.first : ram_rdata.last;
    assign cmp_lt    = last_frame_reg < cmp_b;
    assign frame_inc = last_frame_reg + FRAME_W'(1);

    assign ram_req.we    = cmd_fire && (func_t'(cmd.func) == FUNC_LOAD)
                           && (32'(cmd.entry_index) < MAX_REGIONS);
    assign ram_req.waddr = RIDX_W'(cmd.entry_index);
    assign ram_req.wdata = '{first: cmd.region_start_frame, last: cmd.region_end_frame};
    assign ram_req.raddr = RIDX_W'(walk_reg);

    always_comb
    begin
        state_next      = state_reg;
        cur_region_next = cur_region_reg;
        last_frame_next = last_frame_reg;
        none_given_next = none_given_reg;
        walk_next       = walk_reg;
        usable_next     = usable_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    res_addr_next   = '0;
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                    case (func_t'(cmd.func))
                        FUNC_START:
                        begin
                            if (map_entries == '0)
                            begin
                                res_status_next = ST_NO_ENTRIES;
                            end
                            else
                            begin
                                cur_region_next = '0;
                                none_given_next = 1'b1;
                            end
                        end
                        FUNC_ALLOC:
                        begin
                            usable_next = usable_c;
                            walk_next   = CNT_W'(cur_region_reg);
                            state_next  = S_CHECK;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                if (walk_reg < usable_reg)
                begin
                    state_next = S_TEST_LO;
                end
                else
                begin
                    res_status_next = ST_EXHAUSTED;
                    state_next      = S_DONE;
                end
            end
            S_TEST_LO:
            begin
                if (none_given_reg || cmp_lt)
                begin
                    cur_region_next = RIDX_W'(walk_reg);
                    last_frame_next = ram_rdata.first;
                    none_given_next = 1'b0;
                    res_addr_next   = ADDR_W'(ram_rdata.first) << FRAME_SHIFT;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_TEST_HI;
                end
            end
            S_TEST_HI:
            begin
                if (cmp_lt)
                begin
                    cur_region_next = RIDX_W'(walk_reg);
                    last_frame_next = frame_inc;
                    none_given_next = 1'b0;
                    res_addr_next   = ADDR_W'(frame_inc) << FRAME_SHIFT;
                    state_next      = S_DONE;
                end
                else
                begin
                    walk_next  = walk_reg + CNT_W'(1);
                    state_next = S_CHECK;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = res_addr_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_region_reg <= '0;
            last_frame_reg <= '0;
            none_given_reg <= 1'b1;
            walk_reg       <= '0;
            usable_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_region_reg <= cur_region_next;
            last_frame_reg <= last_frame_next;
            none_given_reg <= none_given_next;
            walk_reg       <= walk_next;
            usable_reg     <= usable_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.frame_address = out_addr_reg;
    assign rsp.status        = out_status_reg;

    `SFA_ASSERT(a_err_addr_zero, (rsp.valid && (rsp.status != ST_OK)) |-> (rsp.frame_address == '0), "error response carries a nonzero frame address")
    `SFA_ASSERT(a_walk_in_range, ((state_reg == S_TEST_LO) || (state_reg == S_TEST_HI)) |-> (walk_reg < usable_reg), "region walk beyond usable count")
    `SFA_ASSERT_NEXT(a_hit_marks_given, (state_reg == S_TEST_HI) && cmp_lt, !none_given_reg && (last_frame_reg == $past(frame_inc)), "allocated frame not recorded")
    `SFA_ASSERT(a_idle_holds_state, ((state_reg == S_IDLE) && !cmd_fire) |=> ($stable(cur_region_reg) && $stable(last_frame_reg) && $stable(none_given_reg)), "allocator state moved while idle")

endmodule

FILE: src/sequential_frame_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequential frame allocator
// Bump allocator handing out 4 KiB frames from a loaded region table.
// ----------------------------------------------------------------------------
// Takes one command at a time and returns exactly one response per command.
// A load or start command goes straight to its response.
// An allocate command walks the region table from the current region: a
// region hits on its first frame, or by stepping past the last frame given,
// and a region that does neither is skipped; exhaustion is reported once
// the walk reaches the usable region count.
// Each region is read from the table RAM and tested against the last frame
// given by one shared comparator, first against the region's first frame,
// then against its last frame.
// The command channel is ready again in the cycle after the response is
// registered; the response waits in its own register until transferred.
// map_entries is to be written over the APB-style port only while no command
// is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sequential_frame_allocator_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    sfa_cmd_if.sink                         cmd,
    sfa_rsp_if.source                       rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sfa_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sfa_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sfa_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import sfa_pkg::*;

    logic [MAP_W-1:0] map_entries;
    ram_req_t         ram_req;
    region_t          ram_rdata;

    sfa_apb_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .map_entries (map_entries)
    );

    sfa_ram #(
        .WIDTH ($bits(region_t)),
        .DEPTH (MAX_REGIONS)
    ) u_region_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    sfa_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rsp         (rsp),
        .map_entries (map_entries),
        .ram_req     (ram_req),
        .ram_rdata   (ram_rdata)
    );

endmodule

FILE: dv/sequential_frame_allocator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequential frame allocator testbench
// Drives load, start and allocate commands over the command channel and
// writes map_entries over the APB-style port while the block is idle. A
// predictor keeps its own copy of the region table and allocation state and
// queues one expected response per command; a checker compares every
// response transfer field by field. Directed tests cover the empty map, the
// region walk with inverted and top-of-memory regions and the map limits;
// then a long hold-off on the response side, then random sessions.
// ----------------------------------------------------------------------------
module sequential_frame_allocator_unit_tb;
    import sfa_pkg::*;

    localparam logic [FUNC_W-1:0]  FUNC_NONE   = 2'd3;
    localparam logic [FRAME_W-1:0] FRAME_TOP   = '1;
    localparam int                 CLK_HALF    = 10;
    localparam int                 IDLE_GUARD  = 64;
    localparam int                 DRAIN_LIMIT = 20000;
    localparam int                 ITEM_TARGET = 1650;
    localparam int                 HOLD_CYCLES = 300;
    localparam int                 PRINT_LIMIT = 50;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        status_t           status;
    } grant_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sfa_cmd_if cmd_ch ();
    sfa_rsp_if rsp_ch ();

    sequential_frame_allocator_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [FRAME_W-1:0] table_first [MAX_REGIONS];
    logic [FRAME_W-1:0] table_last  [MAX_REGIONS];
    int                 walk_region;
    logic [FRAME_W-1:0] last_frame;
    bit                 nothing_given;
    int                 map_count;

    grant_t             grant_q [$];
    int                 error_count;
    int                 print_count;
    int                 items_sent;
    bit                 tx_idle_on;
    bit                 rx_idle_on;
    int                 rx_hold;
    int                 rx_stall;
    logic [FRAME_W-1:0] layout_cursor;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL sequential_frame_allocator_unit");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic logic [FRAME_W-1:0] rand_frame();
        return FRAME_W'({$urandom, $urandom});
    endfunction

    function automatic bit region_has_frame(input int r, output logic [FRAME_W-1:0] frame);
        frame = '0;
        if (nothing_given || last_frame < table_first[r])
        begin
            frame = table_first[r];
            return 1'b1;
        end
        if (last_frame < table_last[r])
        begin
            frame = last_frame + 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic grant_t compute_grant(input logic [FUNC_W-1:0]  f,
                                             input logic [INDEX_W-1:0] idx,
                                             input logic [FRAME_W-1:0] lo,
                                             input logic [FRAME_W-1:0] hi);
        grant_t             g;
        int                 usable;
        int                 r;
        bit                 found;
        logic [FRAME_W-1:0] frame;
        g.addr   = '0;
        g.status = ST_OK;
        found    = 1'b0;
        frame    = '0;
        case (f)
            FUNC_LOAD:
            begin
                table_first[idx] = lo;
                table_last[idx]  = hi;
            end
            FUNC_START:
            begin
                if (map_count < 1)
                    g.status = ST_NO_ENTRIES;
                else
                begin
                    walk_region   = 0;
                    nothing_given = 1'b1;
                end
            end
            FUNC_ALLOC:
            begin
                usable = (map_count == 0) ? 0 : map_count - 1;
                if (usable > MAX_REGIONS)
                    usable = MAX_REGIONS;
                if (walk_region < usable && region_has_frame(walk_region, frame))
                    found = 1'b1;
                else
                begin
                    for (r = walk_region + 1; r < usable && !found; r++)
                    begin
                        if (region_has_frame(r, frame))
                        begin
                            walk_region = r;
                            found       = 1'b1;
                        end
                    end
                end
                if (found)
                begin
                    last_frame    = frame;
                    nothing_given = 1'b0;
                    g.addr        = ADDR_W'(last_frame) << FRAME_SHIFT;
                end
                else
                    g.status = ST_EXHAUSTED;
            end
            default:
            begin
            end
        endcase
        return g;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (print_count < PRINT_LIMIT)
            $display("%0t ns mismatch %s: got %h want %h", $time, what, got, want);
        print_count++;
        error_count++;
    endtask

    task automatic send_cmd(input logic [FUNC_W-1:0]  f,
                            input logic [INDEX_W-1:0] idx,
                            input logic [FRAME_W-1:0] lo,
                            input logic [FRAME_W-1:0] hi);
        int gap;
        cmd_ch.valid              <= 1'b1;
        cmd_ch.func               <= f;
        cmd_ch.entry_index        <= idx;
        cmd_ch.region_start_frame <= lo;
        cmd_ch.region_end_frame   <= hi;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        grant_q.push_back(compute_grant(f, idx, lo, hi));
        items_sent++;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_load(input int idx, input logic [FRAME_W-1:0] lo,
                             input logic [FRAME_W-1:0] hi);
        send_cmd(FUNC_LOAD, INDEX_W'(idx), lo, hi);
    endtask

    task automatic send_start();
        send_cmd(FUNC_START, INDEX_W'($urandom), rand_frame(), rand_frame());
    endtask

    task automatic send_alloc();
        send_cmd(FUNC_ALLOC, INDEX_W'($urandom), rand_frame(), rand_frame());
    endtask

    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        while (grant_q.size() != 0)
            @(posedge clk);
        repeat (IDLE_GUARD) @(posedge clk);
    endtask

    task automatic write_map_entries(input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MAP_ENTRIES, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        map_count = value;
    endtask

    task automatic pick_region(output logic [FRAME_W-1:0] lo, output logic [FRAME_W-1:0] hi);
        int sel;
        int len;
        sel = $urandom_range(0, 9);
        len = $urandom_range(0, 6);
        if (sel < 5)
        begin
            lo            = layout_cursor + FRAME_W'($urandom_range(0, 3));
            hi            = lo + FRAME_W'(len);
            layout_cursor = hi + 1'b1;
        end
        else if (sel < 7)
        begin
            lo = rand_frame();
            hi = lo + FRAME_W'(len);
        end
        else if (sel == 7)
        begin
            lo = rand_frame() | FRAME_W'(16);
            hi = lo - FRAME_W'($urandom_range(1, 8));
        end
        else if (sel == 8)
        begin
            lo = $urandom_range(0, 1) ? '0 : FRAME_TOP - FRAME_W'(len);
            hi = lo + FRAME_W'(len);
        end
        else
        begin
            lo = rand_frame();
            hi = lo;
        end
    endtask

    task automatic test_empty_map();
        write_map_entries(0);
        send_load(0, '0, FRAME_W'(1));
        send_load(1, FRAME_W'(10), FRAME_W'(5));
        send_load(2, FRAME_W'(8), FRAME_W'(9));
        send_load(3, FRAME_TOP - 1'b1, FRAME_TOP);
        send_alloc();
        send_start();
        send_cmd(FUNC_NONE, INDEX_W'($urandom), rand_frame(), rand_frame());
    endtask

    task automatic test_region_walk();
        wait_idle();
        write_map_entries(5);
        repeat (7) send_alloc();
    endtask

    task automatic test_map_limits();
        wait_idle();
        write_map_entries(3);
        send_alloc();
        wait_idle();
        write_map_entries(1);
        send_start();
        send_alloc();
        wait_idle();
        write_map_entries(16);
        send_start();
        repeat (3) send_alloc();
    endtask

    task automatic test_backpressure();
        logic [FRAME_W-1:0] lo;
        logic [FRAME_W-1:0] hi;
        wait_idle();
        tx_idle_on    = 1'b0;
        layout_cursor = FRAME_W'(32);
        rx_hold       = HOLD_CYCLES;
        for (int i = 4; i < MAX_REGIONS; i++)
        begin
            pick_region(lo, hi);
            send_load(i, lo, hi);
        end
        send_start();
        repeat (12) send_alloc();
        tx_idle_on = 1'b1;
    endtask

    task automatic test_random_sessions();
        int                 sel;
        int                 map_val;
        int                 k;
        logic [FRAME_W-1:0] lo;
        logic [FRAME_W-1:0] hi;
        while (items_sent < ITEM_TARGET)
        begin
            wait_idle();
            sel = $urandom_range(0, 9);
            if (sel == 0)
                map_val = 0;
            else if (sel == 1)
                map_val = 1;
            else if (sel == 2)
                map_val = 16;
            else
                map_val = $urandom_range(2, 16);
            write_map_entries(map_val);
            tx_idle_on    = ($urandom_range(0, 3) != 0);
            rx_idle_on    = ($urandom_range(0, 3) != 0);
            layout_cursor = rand_frame() >> $urandom_range(0, 51);
            k             = $urandom_range(1, MAX_REGIONS);
            for (int i = 0; i < k; i++)
            begin
                pick_region(lo, hi);
                if ($urandom_range(0, 9) == 0)
                    send_load($urandom_range(0, MAX_REGIONS - 1), lo, hi);
                else
                    send_load(i, lo, hi);
            end
            if ($urandom_range(0, 9) != 0)
                send_start();
            repeat ($urandom_range(1, 40))
            begin
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    send_cmd(FUNC_NONE, INDEX_W'($urandom), rand_frame(), rand_frame());
                else if (sel == 1)
                begin
                    pick_region(lo, hi);
                    send_load($urandom_range(0, MAX_REGIONS - 1), lo, hi);
                end
                else if (sel == 2)
                    send_start();
                else
                    send_alloc();
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rx_hold--;
            end
            else if (rx_stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rx_stall--;
            end
            else if (rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                rx_stall = pick_gap();
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        grant_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (grant_q.size() == 0)
                    report_mismatch("unexpected response", rsp_ch.frame_address, '0);
                else
                begin
                    want = grant_q.pop_front();
                    if (rsp_ch.frame_address !== want.addr)
                        report_mismatch("frame_address", rsp_ch.frame_address, want.addr);
                    if (rsp_ch.status !== want.status)
                        report_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
                end
            end
        end
    end

    initial
    begin
        int wait_cycles;
        error_count               = 0;
        print_count               = 0;
        items_sent                = 0;
        tx_idle_on                = 1'b1;
        rx_idle_on                = 1'b1;
        rx_hold                   = 0;
        rx_stall                  = 0;
        walk_region               = 0;
        last_frame                = '0;
        nothing_given             = 1'b1;
        map_count                 = 0;
        layout_cursor             = '0;
        rst_n                     <= 1'b0;
        psel                      <= 1'b0;
        penable                   <= 1'b0;
        pwrite                    <= 1'b0;
        paddr                     <= '0;
        pwdata                    <= '0;
        cmd_ch.valid              <= 1'b0;
        cmd_ch.func               <= FUNC_LOAD;
        cmd_ch.entry_index        <= '0;
        cmd_ch.region_start_frame <= '0;
        cmd_ch.region_end_frame   <= '0;
        rsp_ch.ready              <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_map();
        test_region_walk();
        test_map_limits();
        test_backpressure();
        test_random_sessions();

        cmd_ch.valid <= 1'b0;
        wait_cycles = 0;
        while (grant_q.size() != 0 && wait_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (grant_q.size() != 0)
        begin
            $display("FAIL sequential_frame_allocator_unit");
            $finish;
        end
        else
        begin
            repeat (IDLE_GUARD) @(posedge clk);
            if (error_count == 0 && grant_q.size() == 0)
                $display("PASS sequential_frame_allocator_unit");
            else
                $display("FAIL sequential_frame_allocator_unit");
            $finish;
        end
    end

endmodule
